// ===== design/bct_pkg.sv =====
// Shared constants, codes and types of the bucketed connection table.
package bct_pkg;

   localparam int BUCKETS     = 64;
   localparam int SLOTS       = 8;
   localparam int BUCKET_W    = $clog2(BUCKETS);
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int FILL_W      = $clog2(SLOTS + 1);
   localparam int SLOT_ADDR_W = BUCKET_W + SLOT_W;
   localparam int TOTAL_W     = 10;
   localparam int COUNT_W     = 7;
   localparam int KEY_W       = 16;
   localparam int PEER_ADDR_W = 32;
   localparam int PORT_W      = 16;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int MOD_STEPS   = KEY_W / 2;
   localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD,
      S_FILL,
      S_SCAN,
      S_ERASE_RD,
      S_ERASE_WR
   } state_type;

   // One stored connection; key in the low bits, then port, then address.
   typedef struct packed {
      logic [PEER_ADDR_W-1:0] peer_address;
      logic [PORT_W-1:0]      peer_port;
      logic [KEY_W-1:0]       conn_key;
   } entry_type;

   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [BUCKET_W-1:0] rd_addr;
      logic [BUCKET_W-1:0] wr_addr;
      logic [FILL_W-1:0]   wr_data;
   } fill_req_type;

   typedef struct packed {
      logic                   rd_en;
      logic                   wr_en;
      logic [SLOT_ADDR_W-1:0] addr;
      entry_type              wr_data;
   } slot_req_type;

endpackage

// ===== design/bct_mod.sv =====
// Iterative key-modulo-bucket-count unit, two key bits per cycle.
module bct_mod (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bct_pkg::KEY_W-1:0]    dividend,
   input  logic [bct_pkg::COUNT_W-1:0]  divisor,
   output logic                         done,
   output logic [bct_pkg::BUCKET_W-1:0] remainder
);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [bct_pkg::MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [bct_pkg::COUNT_W-1:0]   rem_ff, rem_in;
   logic [bct_pkg::COUNT_W-1:0]   div_ff, div_in;
   logic [bct_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [bct_pkg::COUNT_W:0]     step_a;
   logic [bct_pkg::COUNT_W:0]     step_b;

   // Two restoring steps: shift in a key bit, subtract divisor if it fits
   always_comb begin
      step_a = {rem_ff, key_ff[bct_pkg::KEY_W-1]};
      if (step_a >= {1'b0, div_ff}) begin
         step_a = step_a - {1'b0, div_ff};
      end
      step_b = {step_a[bct_pkg::COUNT_W-1:0], key_ff[bct_pkg::KEY_W-2]};
      if (step_b >= {1'b0, div_ff}) begin
         step_b = step_b - {1'b0, div_ff};
      end
   end

   // Sequence the steps
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      key_in  = key_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         div_in = divisor;
         key_in = dividend;
      end else if (run_ff) begin
         rem_in = step_b[bct_pkg::COUNT_W-1:0];
         key_in = {key_ff[bct_pkg::KEY_W-3:0], 2'b00};
         cnt_in = cnt_ff + bct_pkg::MOD_CNT_W'(1);
         if (cnt_ff == bct_pkg::MOD_CNT_W'(bct_pkg::MOD_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      key_ff <= key_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[bct_pkg::BUCKET_W-1:0];

endmodule

// ===== design/bct_fill.sv =====
// Bucket fill memory with per-bucket valid bits so that reset reads as empty.
module bct_fill (
   input  logic                        clock,
   input  logic                        reset,
   input  bct_pkg::fill_req_type       req,
   output logic [bct_pkg::FILL_W-1:0]  rd_data
);

   logic [bct_pkg::FILL_W-1:0] fill_mem [bct_pkg::BUCKETS];
   logic [bct_pkg::BUCKETS-1:0] valid_ff;
   logic [bct_pkg::FILL_W-1:0] rd_data_ff;
   logic                       rd_valid_ff;

   // Write and read the storage array
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         fill_mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= fill_mem[req.rd_addr];
      end
   end

   // Mark written buckets; reset empties every bucket at once
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            valid_ff[req.wr_addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_valid_ff <= valid_ff[req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== design/bct_slots.sv =====
// Single-port slot memory holding the stored connection entries.
module bct_slots (
   input  logic                  clock,
   input  bct_pkg::slot_req_type req,
   output bct_pkg::entry_type    rd_data
);

   bct_pkg::entry_type slot_mem [bct_pkg::BUCKETS * bct_pkg::SLOTS];
   bct_pkg::entry_type rd_data_ff;

   // Write or read one entry per cycle
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         slot_mem[req.addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= slot_mem[req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bucketed_connection_table.sv =====
// Top level of the bucketed connection table: command sequencer and state.
//
// Usage: drive req_operation (insert, erase, lookup), req_conn_key,
// req_peer_address and req_peer_port and raise start; the word is taken at
// a clock edge where start is high and busy is low. Exactly one response
// word follows, shown on the rsp_ ports for one cycle with rsp_valid high;
// the receiver must take it then, it cannot hold it off.
// Sequence: the key-modulo-bucket-count unit runs first, then the bucket
// fill read is issued and its data used, and insert and unknown operations
// answer from that data; erase and lookup scan the bucket through the slot
// memory, one slot per cycle with registered reads, and an erase then reads
// the bucket's last entry and writes it into the freed slot. busy drops in
// the cycle the response word shows, so the next command can go at the edge
// that takes the response: one command at a time.
// csr_write_enable with csr_write_data sets the bucket count; write it only
// while idle. Reset empties every bucket, zeroes the entry total and sets
// the bucket count to 64.
module bucketed_connection_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [bct_pkg::OP_W-1:0]        req_operation,
   input  logic [bct_pkg::KEY_W-1:0]       req_conn_key,
   input  logic [bct_pkg::PEER_ADDR_W-1:0] req_peer_address,
   input  logic [bct_pkg::PORT_W-1:0]      req_peer_port,
   output logic                            rsp_valid,
   output logic [bct_pkg::STATUS_W-1:0]    rsp_status,
   output logic [bct_pkg::PEER_ADDR_W-1:0] rsp_found_address,
   output logic [bct_pkg::PORT_W-1:0]      rsp_found_port,
   output logic [bct_pkg::TOTAL_W-1:0]     rsp_entry_total,
   input  logic                            csr_write_enable,
   input  logic [bct_pkg::COUNT_W-1:0]     csr_write_data
);

   bct_pkg::state_type              state_ff, state_in;
   logic [bct_pkg::OP_W-1:0]        op_ff, op_in;
   logic [bct_pkg::KEY_W-1:0]       key_ff, key_in;
   logic [bct_pkg::PEER_ADDR_W-1:0] addr_ff, addr_in;
   logic [bct_pkg::PORT_W-1:0]      port_ff, port_in;
   logic [bct_pkg::BUCKET_W-1:0]    bucket_ff, bucket_in;
   logic [bct_pkg::FILL_W-1:0]      fill_ff, fill_in;
   logic [bct_pkg::FILL_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                            pend_ff, pend_in;
   logic [bct_pkg::SLOT_W-1:0]      pend_idx_ff, pend_idx_in;
   logic [bct_pkg::SLOT_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [bct_pkg::TOTAL_W-1:0]     total_ff, total_in;
   logic [bct_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bct_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [bct_pkg::PEER_ADDR_W-1:0] rsp_found_address_ff, rsp_found_address_in;
   logic [bct_pkg::PORT_W-1:0]      rsp_found_port_ff, rsp_found_port_in;
   logic [bct_pkg::TOTAL_W-1:0]     rsp_entry_total_ff, rsp_entry_total_in;

   logic [bct_pkg::COUNT_W-1:0]     count_eff;
   logic                            mod_start;
   logic                            mod_done;
   logic [bct_pkg::BUCKET_W-1:0]    mod_rem;
   bct_pkg::fill_req_type           fill_req;
   logic [bct_pkg::FILL_W-1:0]      fill_rdata;
   bct_pkg::slot_req_type           slot_req;
   bct_pkg::entry_type              slot_rdata;
   logic                            scan_issue;
   logic [bct_pkg::SLOT_W-1:0]      last_idx;

   // Clamp the bucket count to the range of buckets that exist
   always_comb begin
      count_eff = count_ff;
      if (count_ff == '0) begin
         count_eff = bct_pkg::COUNT_W'(1);
      end else if (count_ff > bct_pkg::COUNT_W'(bct_pkg::BUCKETS)) begin
         count_eff = bct_pkg::COUNT_W'(bct_pkg::BUCKETS);
      end
   end

   bct_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (key_in),
      .divisor   (count_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   bct_fill u_fill (
      .clock   (clock),
      .reset   (reset),
      .req     (fill_req),
      .rd_data (fill_rdata)
   );

   bct_slots u_slots (
      .clock   (clock),
      .req     (slot_req),
      .rd_data (slot_rdata)
   );

   assign scan_issue = scan_idx_ff < fill_ff;
   assign last_idx   = bct_pkg::SLOT_W'(fill_ff - bct_pkg::FILL_W'(1));

   // Sequence one command: modulo, fill read, scan, update
   always_comb begin
      state_in             = state_ff;
      op_in                = op_ff;
      key_in               = key_ff;
      addr_in              = addr_ff;
      port_in              = port_ff;
      bucket_in            = bucket_ff;
      fill_in              = fill_ff;
      scan_idx_in          = scan_idx_ff;
      pend_in              = 1'b0;
      pend_idx_in          = pend_idx_ff;
      hit_idx_in           = hit_idx_ff;
      total_in             = total_ff;
      rsp_valid_in         = 1'b0;
      rsp_status_in        = rsp_status_ff;
      rsp_found_address_in = rsp_found_address_ff;
      rsp_found_port_in    = rsp_found_port_ff;
      rsp_entry_total_in   = rsp_entry_total_ff;
      mod_start            = 1'b0;
      fill_req             = '0;
      slot_req             = '0;
      slot_req.wr_data     = '{peer_address: addr_ff, peer_port: port_ff, conn_key: key_ff};

      unique case (state_ff)
         bct_pkg::S_IDLE: begin
            if (start) begin
               op_in     = req_operation;
               key_in    = req_conn_key;
               addr_in   = req_peer_address;
               port_in   = req_peer_port;
               mod_start = 1'b1;
               state_in  = bct_pkg::S_MOD;
            end
         end

         bct_pkg::S_MOD: begin
            if (mod_done) begin
               bucket_in        = mod_rem;
               fill_req.rd_en   = 1'b1;
               fill_req.rd_addr = mod_rem;
               state_in         = bct_pkg::S_FILL;
            end
         end

         bct_pkg::S_FILL: begin
            fill_in              = fill_rdata;
            scan_idx_in          = '0;
            rsp_found_address_in = '0;
            rsp_found_port_in    = '0;
            rsp_entry_total_in   = total_ff;
            case (op_ff)
               bct_pkg::OP_INSERT: begin
                  rsp_valid_in = 1'b1;
                  state_in     = bct_pkg::S_IDLE;
                  if (fill_rdata >= bct_pkg::FILL_W'(bct_pkg::SLOTS)) begin
                     rsp_status_in = bct_pkg::STAT_FULL;
                  end else begin
                     slot_req.wr_en   = 1'b1;
                     slot_req.addr    = {bucket_ff, fill_rdata[bct_pkg::SLOT_W-1:0]};
                     fill_req.wr_en   = 1'b1;
                     fill_req.wr_addr = bucket_ff;
                     fill_req.wr_data = fill_rdata + bct_pkg::FILL_W'(1);
                     total_in         = total_ff + bct_pkg::TOTAL_W'(1);
                     rsp_entry_total_in = total_in;
                     rsp_status_in    = bct_pkg::STAT_OK;
                  end
               end
               bct_pkg::OP_ERASE, bct_pkg::OP_LOOKUP: begin
                  state_in = bct_pkg::S_SCAN;
               end
               default: begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bct_pkg::STAT_MISS;
                  state_in      = bct_pkg::S_IDLE;
               end
            endcase
         end

         bct_pkg::S_SCAN: begin
            // Compare the slot read last cycle while reading the next one
            if (pend_ff && slot_rdata.conn_key == key_ff) begin
               if (op_ff == bct_pkg::OP_LOOKUP) begin
                  rsp_valid_in         = 1'b1;
                  rsp_status_in        = bct_pkg::STAT_OK;
                  rsp_found_address_in = slot_rdata.peer_address;
                  rsp_found_port_in    = slot_rdata.peer_port;
                  state_in             = bct_pkg::S_IDLE;
               end else begin
                  hit_idx_in = pend_idx_ff;
                  state_in   = bct_pkg::S_ERASE_RD;
               end
            end else if (!scan_issue) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = bct_pkg::STAT_MISS;
               state_in      = bct_pkg::S_IDLE;
            end else begin
               slot_req.rd_en = 1'b1;
               slot_req.addr  = {bucket_ff, scan_idx_ff[bct_pkg::SLOT_W-1:0]};
               scan_idx_in    = scan_idx_ff + bct_pkg::FILL_W'(1);
               pend_in        = 1'b1;
               pend_idx_in    = scan_idx_ff[bct_pkg::SLOT_W-1:0];
            end
         end

         bct_pkg::S_ERASE_RD: begin
            slot_req.rd_en = 1'b1;
            slot_req.addr  = {bucket_ff, last_idx};
            state_in       = bct_pkg::S_ERASE_WR;
         end

         bct_pkg::S_ERASE_WR: begin
            // Move the last entry into the freed slot and shrink the bucket
            slot_req.wr_en     = 1'b1;
            slot_req.addr      = {bucket_ff, hit_idx_ff};
            slot_req.wr_data   = slot_rdata;
            fill_req.wr_en     = 1'b1;
            fill_req.wr_addr   = bucket_ff;
            fill_req.wr_data   = fill_ff - bct_pkg::FILL_W'(1);
            total_in           = total_ff - bct_pkg::TOTAL_W'(1);
            rsp_valid_in       = 1'b1;
            rsp_status_in      = bct_pkg::STAT_OK;
            rsp_entry_total_in = total_in;
            state_in           = bct_pkg::S_IDLE;
         end

         default: begin
            state_in = bct_pkg::S_IDLE;
         end
      endcase
   end

   // Take bucket count writes
   always_comb begin
      count_in = count_ff;
      if (csr_write_enable) begin
         count_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bct_pkg::S_IDLE;
         pend_ff      <= 1'b0;
         total_ff     <= '0;
         count_ff     <= bct_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff                <= op_in;
      key_ff               <= key_in;
      addr_ff              <= addr_in;
      port_ff              <= port_in;
      bucket_ff            <= bucket_in;
      fill_ff              <= fill_in;
      scan_idx_ff          <= scan_idx_in;
      pend_idx_ff          <= pend_idx_in;
      hit_idx_ff           <= hit_idx_in;
      rsp_status_ff        <= rsp_status_in;
      rsp_found_address_ff <= rsp_found_address_in;
      rsp_found_port_ff    <= rsp_found_port_in;
      rsp_entry_total_ff   <= rsp_entry_total_in;
   end

   assign busy              = (state_ff != bct_pkg::S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_address = rsp_found_address_ff;
   assign rsp_found_port    = rsp_found_port_ff;
   assign rsp_entry_total   = rsp_entry_total_ff;

endmodule
